[rtl/core/proper_divisor_sum_amicable_unit_defines.svh]
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef PROPER_DIVISOR_SUM_AMICABLE_UNIT_DEFINES_SVH
`define PROPER_DIVISOR_SUM_AMICABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PDSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PDSA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDSA_ASSERT(label, clk, rst_n, prop, msg)
`define PDSA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[rtl/core/pdsa_pkg.sv]
package pdsa_pkg;

  localparam int NUM_WIDTH_DEF = 32;
  localparam int CNT_W         = 11;
  localparam int SUM_W         = 35;

  // controller -> datapath
  typedef struct packed {
    logic load_num;     // capture number, open first pass
    logic start_pass2;  // save first-pass result, open pass on the sum
    logic div_init;     // load dividend, clear remainder
    logic div_step;     // one restoring-division bit
    logic accum;        // add divisor pair, advance trial divisor
    logic emit;         // register the result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sq_le;        // trial divisor squared <= target
    logic amic_go;      // first-pass sum qualifies for partner search
    logic pass2;        // second pass is running
  } sts_t;

endpackage

[rtl/core/pdsa_datapath.sv]
module pdsa_datapath #(
  parameter int NUM_WIDTH = pdsa_pkg::NUM_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pdsa_pkg::cmd_t             cmd,
  output pdsa_pkg::sts_t             sts,
  input  logic [NUM_WIDTH-1:0]       in_number,
  input  logic [NUM_WIDTH-1:0]       limit,
  output logic                       out_valid,
  output logic [pdsa_pkg::CNT_W-1:0] out_divisor_count,
  output logic [pdsa_pkg::SUM_W-1:0] out_divisor_sum,
  output logic                       out_is_perfect,
  output logic                       out_is_amicable,
  output logic [NUM_WIDTH-1:0]       out_amicable_partner
);

  localparam int W   = NUM_WIDTH;
  localparam int DW  = (W + 1) / 2 + 1;
  localparam int CW  = pdsa_pkg::CNT_W;
  localparam int SW  = pdsa_pkg::SUM_W;

  logic [W-1:0]  n_r, target_r;
  logic [DW-1:0] d_r;
  logic [W:0]    sq_r;
  logic [CW-1:0] cnt_r, cnt1_r;
  logic [SW-1:0] sum_r, sum1_r;
  logic          pass2_r;
  logic [W-1:0]  quo_r, rem_r;

  logic          valid_r;
  logic [CW-1:0] ocnt_r;
  logic [SW-1:0] osum_r;
  logic          operf_r, oamic_r;
  logic [W-1:0]  opart_r;

  logic [W:0]    shifted;
  logic          fits;
  logic [W:0]    d_ext_w1;
  logic [W-1:0]  d_ext;
  logic          add_d, add_q;
  logic [CW-1:0] cnt_nxt;
  logic [SW-1:0] sum_nxt;
  logic [SW-1:0] n_ext, limit_ext;
  logic [SW-1:0] p1_sum;
  logic [CW-1:0] p1_cnt;
  logic          perfect, amicable;

  assign d_ext    = W'(d_r);
  assign d_ext_w1 = (W + 1)'(d_r);
  assign shifted  = {rem_r, quo_r[W-1]};
  assign fits     = (shifted >= d_ext_w1);

  // divisor pair (d, q) once remainder is zero; skip target itself and repeated root
  assign add_d = (rem_r == '0) && (d_ext != target_r);
  assign add_q = (rem_r == '0) && (quo_r != d_ext) && (quo_r != target_r);

  assign cnt_nxt = cnt_r + CW'(add_d) + CW'(add_q);
  assign sum_nxt = sum_r + (add_d ? SW'(d_ext) : '0) + (add_q ? SW'(quo_r) : '0);

  assign n_ext     = SW'(n_r);
  assign limit_ext = SW'(limit);

  assign p1_sum   = pass2_r ? sum1_r : sum_r;
  assign p1_cnt   = pass2_r ? cnt1_r : cnt_r;
  assign perfect  = (n_r >= W'(2)) && (p1_sum == n_ext);
  assign amicable = pass2_r && (sum_r == n_ext);

  assign sts.sq_le   = (sq_r <= (W + 1)'(target_r));
  assign sts.amic_go = (n_r >= W'(2)) && (sum_r > n_ext) && (sum_r <= limit_ext);
  assign sts.pass2   = pass2_r;

  always_ff @(posedge clk) begin
    if (cmd.load_num) begin
      n_r      <= in_number;
      target_r <= in_number;
      d_r      <= DW'(1);
      sq_r     <= (W + 1)'(1);
      cnt_r    <= '0;
      sum_r    <= '0;
    end else if (cmd.start_pass2) begin
      cnt1_r   <= cnt_r;
      sum1_r   <= sum_r;
      target_r <= sum_r[W-1:0];
      d_r      <= DW'(1);
      sq_r     <= (W + 1)'(1);
      cnt_r    <= '0;
      sum_r    <= '0;
    end else if (cmd.accum) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      sq_r  <= sq_r + (W + 1)'({d_r, 1'b1});
      d_r   <= d_r + DW'(1);
    end

    if (cmd.div_init) begin
      quo_r <= target_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= fits ? W'(shifted - d_ext_w1) : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], fits};
    end

    if (cmd.emit) begin
      ocnt_r  <= p1_cnt;
      osum_r  <= p1_sum;
      operf_r <= perfect;
      oamic_r <= amicable;
      opart_r <= amicable ? sum1_r[W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass2_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      if (cmd.load_num) begin
        pass2_r <= 1'b0;
      end else if (cmd.start_pass2) begin
        pass2_r <= 1'b1;
      end
    end
  end

  assign out_valid            = valid_r;
  assign out_divisor_count    = ocnt_r;
  assign out_divisor_sum      = osum_r;
  assign out_is_perfect       = operf_r;
  assign out_is_amicable      = oamic_r;
  assign out_amicable_partner = opart_r;

endmodule

[rtl/core/pdsa_ctrl.sv]
`include "proper_divisor_sum_amicable_unit_defines.svh"

module pdsa_ctrl #(
  parameter int NUM_WIDTH = pdsa_pkg::NUM_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pdsa_pkg::sts_t sts,
  output pdsa_pkg::cmd_t cmd
);

  localparam int BW = $clog2(NUM_WIDTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic          bit_last;

  assign bit_last = (bit_r == BW'(NUM_WIDTH - 1));

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_num = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.sq_le) begin
          cmd.div_init = 1'b1;
          bit_nxt      = '0;
          state_nxt    = ST_DIV;
        end else if (!sts.pass2 && sts.amic_go) begin
          cmd.start_pass2 = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r + BW'(1);
        if (bit_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  `PDSA_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy, "accepted word did not raise busy")
  `PDSA_ASSERT(a_acc_after_div, clk, rst_n, cmd.accum |-> $past(cmd.div_step), "accumulate without division")
  `PDSA_ASSERT(a_one_pass2, clk, rst_n, cmd.start_pass2 |-> !sts.pass2, "second pass opened twice")
  `PDSA_ASSERT(a_emit_idle, clk, rst_n, cmd.emit |=> !busy, "result emitted but still busy")
  `PDSA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy, "busy after reset")

endmodule

[rtl/core/proper_divisor_sum_amicable_unit.sv]
// Each pass tries divisors d with d*d <= t, t the number or its divisor sum; a partner
//   search runs a second pass, and out_valid is registered from the emit command.
// Takes one number at a time, paced by the shared bit-serial divider.
// Reset (synchronous, rst_n low): controller idles, limit returns to all ones.
// out_valid pulses one cycle per result; the receiver cannot stall.
module proper_divisor_sum_amicable_unit #(
  parameter int NUM_WIDTH = pdsa_pkg::NUM_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [NUM_WIDTH-1:0]       in_number,
  output logic                       out_valid,
  output logic [pdsa_pkg::CNT_W-1:0] out_divisor_count,
  output logic [pdsa_pkg::SUM_W-1:0] out_divisor_sum,
  output logic                       out_is_perfect,
  output logic                       out_is_amicable,
  output logic [NUM_WIDTH-1:0]       out_amicable_partner,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [NUM_WIDTH-1:0] limit_r;
  logic                 reg_sel;
  pdsa_pkg::cmd_t       cmd;
  pdsa_pkg::sts_t       sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_r <= pwdata[NUM_WIDTH-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(limit_r) : 32'd0;

  pdsa_ctrl #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  pdsa_datapath #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_number           (in_number),
    .limit               (limit_r),
    .out_valid           (out_valid),
    .out_divisor_count   (out_divisor_count),
    .out_divisor_sum     (out_divisor_sum),
    .out_is_perfect      (out_is_perfect),
    .out_is_amicable     (out_is_amicable),
    .out_amicable_partner(out_amicable_partner)
  );

endmodule
